### src/yawdc_pkg.sv
package yawdc_pkg;

    // Register indexes on the configuration port (byte address 8 * index).
    localparam logic [2:0] REG_RATE_DEADBAND       = 3'd0;
    localparam logic [2:0] REG_DEVIATION_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_GAIN_UPHILL         = 3'd2;
    localparam logic [2:0] REG_GAIN_DOWNHILL       = 3'd3;
    localparam logic [2:0] REG_MAX_CORRECTION      = 3'd4;
    localparam logic [2:0] REG_CLIMB_SPEED         = 3'd5;
    localparam logic [2:0] REG_NORMAL_SPEED        = 3'd6;
    localparam logic [2:0] REG_DOWNHILL_BRAKE      = 3'd7;

    // Input item kinds carried on tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // One degree of heading is 65.5 counts per deg/s times 1000 ms per s.
    localparam int unsigned UNITS_PER_DEG = 65500;

    // Correction magnitudes at or above 256 saturate, so products below
    // 256 degrees fit in 24 bits and divide exactly through a reciprocal.
    localparam int unsigned        MAG_OP_W    = 24;
    localparam logic [31:0]        CM_LIMIT    = 32'(256 * UNITS_PER_DEG);
    localparam int unsigned        RECIP_SHIFT = 40;
    localparam longint unsigned    RECIP       =
        (64'd1099511627776 + 64'(UNITS_PER_DEG) - 64'd1) / 64'(UNITS_PER_DEG);

    // Shared signed multiplier operand width.
    localparam int unsigned MUL_W  = 26;
    localparam int unsigned PROD_W = 2 * MUL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_ACCUM,
        ST_ABS,
        ST_MUL_GAIN,
        ST_MUL_RECIP,
        ST_DONE
    } yawdc_state_t;

endpackage

### src/yaw_drift_correction_unit.sv
// Gyro-integrated heading with a proportional differential-drive correction.
// The sequencer takes a new item only in its idle state, once the last one is
// through. For a sample item it runs the rate product, the saturating
// accumulate, the magnitude, the gain product and the divide-by-65500
// reciprocal product one after another through a single shared 26x26
// multiplier and one adder; the reciprocal product is skipped when the
// heading stays under the deviation threshold. A heading reset item goes
// straight to the last step. The output register lets the next item be
// accepted while a result still waits to be taken; a finished item waits in
// its last step only when that register is still full.
module yaw_drift_correction_unit #(
    parameter int ACCUM_WIDTH = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] gyro_z, [31:16] elapsed_ms, [32] climbing, [33] downhill,
    // [42:34] base_override, [47:43] zero
    input  logic [47:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] left_speed, [15:8] right_speed, [24:16] correction,
    // [25] correcting, [73:26] yaw_deviation, [79:74] zero
    output logic [79:0] m_tdata,
    // [0] drive_valid
    output logic        m_tuser
);
    import yawdc_pkg::*;

    localparam int W     = ACCUM_WIDTH;
    localparam int SUM_W = W + 2;
    localparam int CMP_W = (W > 40) ? W : 40;

    // Configuration registers
    logic [15:0] deadband_reg;
    logic [39:0] threshold_reg;
    logic [7:0]  gain_up_reg;
    logic [7:0]  gain_dn_reg;
    logic [7:0]  max_corr_reg;
    logic [7:0]  climb_reg;
    logic [7:0]  normal_reg;
    logic [7:0]  brake_reg;

    yawdc_state_t state_reg, state_next;

    // Latched input item
    logic               op_reg, op_next;
    logic signed [15:0] gz_reg, gz_next;
    logic [15:0]        ms_reg, ms_next;
    logic               climb_in_reg, climb_in_next;
    logic               down_in_reg, down_in_next;
    logic signed [8:0]  ovr_reg, ovr_next;

    // Heading state and working registers
    logic signed [W-1:0]      accum_reg, accum_next;
    logic                     active_reg, active_next;
    logic [W-1:0]             mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic                     sat_reg, sat_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic        drive_reg, drive_next;
    logic [79:0] mdata_reg, mdata_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     in_accept;
    logic                     out_load;

    assign pready    = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= 16'd262;
            threshold_reg <= 40'd163750;
            gain_up_reg   <= 8'd10;
            gain_dn_reg   <= 8'd8;
            max_corr_reg  <= 8'd45;
            climb_reg     <= 8'd200;
            normal_reg    <= 8'd150;
            brake_reg     <= 8'd80;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[5:3])
                REG_RATE_DEADBAND:       deadband_reg  <= pwdata[15:0];
                REG_DEVIATION_THRESHOLD: threshold_reg <= pwdata[39:0];
                REG_GAIN_UPHILL:         gain_up_reg   <= pwdata[7:0];
                REG_GAIN_DOWNHILL:       gain_dn_reg   <= pwdata[7:0];
                REG_MAX_CORRECTION:      max_corr_reg  <= pwdata[7:0];
                REG_CLIMB_SPEED:         climb_reg     <= pwdata[7:0];
                REG_NORMAL_SPEED:        normal_reg    <= pwdata[7:0];
                REG_DOWNHILL_BRAKE:      brake_reg     <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_RATE_DEADBAND:       prdata = {48'd0, deadband_reg};
            REG_DEVIATION_THRESHOLD: prdata = {24'd0, threshold_reg};
            REG_GAIN_UPHILL:         prdata = {56'd0, gain_up_reg};
            REG_GAIN_DOWNHILL:       prdata = {56'd0, gain_dn_reg};
            REG_MAX_CORRECTION:      prdata = {56'd0, max_corr_reg};
            REG_CLIMB_SPEED:         prdata = {56'd0, climb_reg};
            REG_NORMAL_SPEED:        prdata = {56'd0, normal_reg};
            REG_DOWNHILL_BRAKE:      prdata = {56'd0, brake_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_tuser == OP_RESET) ? ST_DONE : ST_MUL_RATE;
                end
            end
            ST_MUL_RATE:  state_next = ST_ACCUM;
            ST_ACCUM:     state_next = ST_ABS;
            ST_ABS:       state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:
            begin
                // Below the deviation threshold nothing more is computed.
                if (CMP_W'(mag_reg) < CMP_W'(threshold_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL_RECIP;
                end
            end
            ST_MUL_RECIP: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs (ready and the shared multiplier's operands)
    logic signed [16:0] gz_ext;
    logic [16:0]        gz_mag;
    logic [7:0]         gain_sel;

    always_comb
    begin
        gz_ext   = 17'(gz_reg);
        gz_mag   = gz_ext[16] ? 17'(~gz_ext + 17'sd1) : 17'(gz_ext);
        gain_sel = down_in_reg ? gain_dn_reg : gain_up_reg;
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_MUL_RATE:
            begin
                // Rates inside the deadband integrate as zero.
                mul_a = (gz_mag < {1'b0, deadband_reg}) ? '0 : MUL_W'(gz_reg);
                mul_b = MUL_W'($signed({1'b0, ms_reg}));
            end
            ST_MUL_GAIN:
            begin
                mul_a = MUL_W'($signed({1'b0, mag_reg[MAG_OP_W-1:0]}));
                mul_b = MUL_W'($signed({1'b0, gain_sel}));
            end
            ST_MUL_RECIP:
            begin
                mul_a = MUL_W'($signed({1'b0, prod_reg[MAG_OP_W-1:0]}));
                mul_b = MUL_W'($signed({1'b0, RECIP[MUL_W-2:0]}));
            end
            ST_ACCUM, ST_ABS, ST_DONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Datapath next values
    logic signed [SUM_W-1:0] sum;
    logic signed [W-1:0]     sat_sum;
    logic [7:0]              quot;
    logic [8:0]              cm;
    logic [7:0]              corr_mag;
    logic signed [9:0]       corr10;
    logic signed [9:0]       base;
    logic signed [10:0]      lsum;
    logic signed [10:0]      rsum;
    logic [7:0]              left_spd;
    logic [7:0]              right_spd;
    logic signed [63:0]      acc64;
    logic                    drive_on;

    always_comb
    begin
        sum = SUM_W'(accum_reg) + SUM_W'($signed(prod_reg[32:0]));
        // Saturate when the guard bits disagree with the accumulator sign.
        if (sum[SUM_W-1:W-1] != {3{sum[SUM_W-1]}})
        begin
            sat_sum = sum[SUM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            sat_sum = sum[W-1:0];
        end

        quot     = prod_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        cm       = sat_reg ? 9'd256 : {1'b0, quot};
        corr_mag = (cm > {1'b0, max_corr_reg}) ? max_corr_reg : cm[7:0];
        corr10   = neg_reg ? -$signed({2'b00, corr_mag}) : $signed({2'b00, corr_mag});

        if (!ovr_reg[8])
        begin
            base = 10'(ovr_reg);
        end
        else if (down_in_reg)
        begin
            base = -$signed({2'b00, brake_reg});
        end
        else if (climb_in_reg)
        begin
            base = $signed({2'b00, climb_reg});
        end
        else
        begin
            base = $signed({2'b00, normal_reg});
        end

        lsum = 11'(base) + 11'(corr10);
        rsum = 11'(base) - 11'(corr10);
        left_spd  = lsum[10] ? 8'd0 : ((lsum > 11'sd255) ? 8'd255 : lsum[7:0]);
        right_spd = rsum[10] ? 8'd0 : ((rsum > 11'sd255) ? 8'd255 : rsum[7:0]);

        acc64    = 64'(accum_reg);
        drive_on = (op_reg == OP_SAMPLE) && active_reg;

        op_next       = op_reg;
        gz_next       = gz_reg;
        ms_next       = ms_reg;
        climb_in_next = climb_in_reg;
        down_in_next  = down_in_reg;
        ovr_next      = ovr_reg;
        accum_next    = accum_reg;
        active_next   = active_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sat_next      = sat_reg;
        prod_next     = prod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = s_tuser;
                    gz_next       = s_tdata[15:0];
                    ms_next       = s_tdata[31:16];
                    climb_in_next = s_tdata[32];
                    down_in_next  = s_tdata[33];
                    ovr_next      = s_tdata[42:34];
                    if (s_tuser == OP_RESET)
                    begin
                        accum_next  = '0;
                        active_next = 1'b0;
                    end
                end
            end
            ST_MUL_RATE:
            begin
                prod_next = mul_p;
            end
            ST_ACCUM:
            begin
                accum_next = sat_sum;
            end
            ST_ABS:
            begin
                neg_next = accum_reg[W-1];
                mag_next = accum_reg[W-1] ? W'(-accum_reg) : W'(accum_reg);
            end
            ST_MUL_GAIN:
            begin
                active_next = !(CMP_W'(mag_reg) < CMP_W'(threshold_reg));
                sat_next    = (mag_reg >= W'(CM_LIMIT)) && (gain_sel != 8'd0);
                prod_next   = mul_p;
            end
            ST_MUL_RECIP:
            begin
                sat_next  = sat_reg || (prod_reg[31:0] >= CM_LIMIT);
                prod_next = mul_p;
            end
            ST_DONE:
            begin
                prod_next = prod_reg;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase

        m_valid_next = m_valid_reg && !m_tready;
        drive_next   = drive_reg;
        mdata_next   = mdata_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            drive_next   = drive_on;
            mdata_next   = {6'd0, acc64[47:0], active_reg,
                            drive_on ? corr10[8:0] : 9'd0,
                            drive_on ? right_spd : 8'd0,
                            drive_on ? left_spd : 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            accum_reg   <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            accum_reg   <= accum_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        gz_reg       <= gz_next;
        ms_reg       <= ms_next;
        climb_in_reg <= climb_in_next;
        down_in_reg  <= down_in_next;
        ovr_reg      <= ovr_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        sat_reg      <= sat_next;
        prod_reg     <= prod_next;
        drive_reg    <= drive_next;
        mdata_reg    <= mdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = drive_reg;
    assign m_tdata  = mdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_reset_clears_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == OP_RESET) |=> (accum_reg == '0 && !active_reg))
        else $error("heading reset item did not clear the accumulator");

    a_sample_starts_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == OP_SAMPLE) |=> (state_reg == ST_MUL_RATE))
        else $error("sample item did not start the multiply sequence");

    a_drive_implies_correcting: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[25])
        else $error("drive issued without the correcting flag");

    a_no_drive_zero_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[24:0] == 25'd0))
        else $error("speeds or correction nonzero on an item without drive");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import yawdc_pkg::*;

    localparam longint ACC_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN      = -ACC_MAX - 1;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     QUIET_LIMIT  = 5000;
    localparam int     PHASE_ITEMS  = 190;
    localparam int     RAMP_ITEMS   = 40;
    localparam int     NUM_DIRECTED = 22;

    typedef struct {
        logic               op;
        logic signed [15:0] gz;
        logic        [15:0] ms;
        logic               climb;
        logic               down;
        logic signed [8:0]  ovr;
    } yaw_sample_t;

    typedef struct {
        logic               drv;
        logic        [7:0]  left;
        logic        [7:0]  right;
        logic signed [8:0]  corr;
        logic               act;
        logic        [47:0] yaw;
    } drive_cmd_t;

    typedef struct {
        yaw_sample_t smp;
        bit          typed;
        drive_cmd_t  want;
    } stim_row_t;

    localparam drive_cmd_t NO_DRIVE = '{1'b0, 8'd0, 8'd0, 9'sd0, 1'b0, 48'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] gyro_z, [31:16] elapsed_ms, [32] climbing, [33] downhill,
    // [42:34] base_override, [47:43] zero
    logic [47:0] s_tdata = '0;
    // [0] operation
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] left_speed, [15:8] right_speed, [24:16] correction,
    // [25] correcting, [73:26] yaw_deviation, [79:74] zero
    logic [79:0] m_tdata;
    // [0] drive_valid
    logic        m_tuser;

    // Shadow copy of the block's registers and heading state.
    longint     cfg_reg [8];
    longint     heading;
    logic       heading_active;

    drive_cmd_t drive_expect_q [$];
    int         mismatch_count = 0;
    int         src_gap_pct = 0;
    int         sink_stall_pct = 0;
    int         quiet_cycles = 0;

    // Directed items under the reset register values.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // Heading reset ignores every other field.
        '{'{OP_RESET, 16'shFFFF, 16'hFFFF, 1'b1, 1'b1, 9'sh0FF}, 1'b1, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'hFFFF, 1'b0, 1'b0, -9'sd1}, 1'b1, NO_DRIVE},
        // Rates just under the deadband count as zero.
        '{'{OP_SAMPLE, 16'sd261, 16'hFFFF, 1'b0, 1'b0, -9'sd1}, 1'b1, NO_DRIVE},
        '{'{OP_SAMPLE, -16'sd261, 16'hFFFF, 1'b1, 1'b0, -9'sd1}, 1'b1, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sh8000, 16'd0, 1'b0, 1'b1, -9'sd1}, 1'b1, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd262, 16'd1000, 1'b0, 1'b0, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b1, 1'b0, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b0, 1'b1, -9'sd1}, 1'b0, NO_DRIVE},
        // Downhill wins when both modes are set.
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b1, 1'b1, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b0, 1'b0, 9'sd255}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b1, 1'b1, 9'sd0}, 1'b0, NO_DRIVE},
        // Any negative override selects by mode, not just minus one.
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b0, 1'b0, 9'sh100}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd0, 16'd0, 1'b1, 1'b0, -9'sd2}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, -16'sd262, 16'd2000, 1'b0, 1'b0, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sh7FFF, 16'hFFFF, 1'b0, 1'b0, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sh8000, 16'hFFFF, 1'b1, 1'b0, 9'sd100}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0, 1'b1, 9'sd20}, 1'b0, NO_DRIVE},
        '{'{OP_RESET, 16'sd12345, 16'd777, 1'b0, 1'b1, 9'sd3}, 1'b1, NO_DRIVE},
        '{'{OP_SAMPLE, 16'sd300, 16'd545, 1'b0, 1'b0, -9'sd1}, 1'b1,
          '{1'b0, 8'd0, 8'd0, 9'sd0, 1'b0, 48'd163500}},
        '{'{OP_SAMPLE, 16'sd1, 16'hFFFF, 1'b0, 1'b0, -9'sd1}, 1'b1,
          '{1'b0, 8'd0, 8'd0, 9'sd0, 1'b0, 48'd163500}},
        // Twelve counts over the deviation threshold, then back under it.
        '{'{OP_SAMPLE, 16'sd262, 16'd1, 1'b0, 1'b0, -9'sd1}, 1'b0, NO_DRIVE},
        '{'{OP_SAMPLE, -16'sd262, 16'd1, 1'b0, 1'b0, -9'sd1}, 1'b0, NO_DRIVE}
    };

    yaw_drift_correction_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advances the heading state by one item and returns the drive it causes.
    function automatic drive_cmd_t predict_drive(yaw_sample_t s);
        drive_cmd_t cmd;
        longint     rate;
        longint     mag;
        longint     gain;
        longint     lim;
        longint     base;
        longint     cm;
        longint     corr;
        cmd = NO_DRIVE;
        if (s.op == OP_RESET)
        begin
            heading = 0;
            heading_active = 1'b0;
        end
        else
        begin
            rate = s.gz;
            if (((rate < 0) ? -rate : rate) < cfg_reg[REG_RATE_DEADBAND])
                rate = 0;
            heading = clamp_to(heading + rate * longint'(s.ms), ACC_MIN, ACC_MAX);
            mag = (heading < 0) ? -heading : heading;
            if (mag < cfg_reg[REG_DEVIATION_THRESHOLD])
                heading_active = 1'b0;
            else
            begin
                heading_active = 1'b1;
                lim = cfg_reg[REG_MAX_CORRECTION];
                gain = s.down ? cfg_reg[REG_GAIN_DOWNHILL] : cfg_reg[REG_GAIN_UPHILL];
                if (s.ovr >= 0)
                    base = s.ovr;
                else if (s.down)
                    base = -cfg_reg[REG_DOWNHILL_BRAKE];
                else if (s.climb)
                    base = cfg_reg[REG_CLIMB_SPEED];
                else
                    base = cfg_reg[REG_NORMAL_SPEED];
                if (gain == 0)
                    cm = 0;
                else if (mag >= longint'(UNITS_PER_DEG) * 256)
                    cm = 256;
                else
                    cm = mag * gain / longint'(UNITS_PER_DEG);
                corr = clamp_to((heading < 0) ? -cm : cm, -lim, lim);
                cmd.drv   = 1'b1;
                cmd.corr  = 9'(corr);
                cmd.left  = 8'(clamp_to(base + corr, 0, 255));
                cmd.right = 8'(clamp_to(base - corr, 0, 255));
            end
        end
        cmd.act = heading_active;
        cmd.yaw = heading[47:0];
        return cmd;
    endfunction

    function automatic yaw_sample_t random_sample();
        yaw_sample_t s;
        int          pick;
        s.op = ($urandom_range(0, 24) == 0) ? OP_RESET : OP_SAMPLE;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            s.gz = 16'($urandom_range(0, 1023) - 512);
        else if (pick < 8)
            s.gz = 16'($urandom);
        else if (pick == 8)
            s.gz = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            s.gz = 16'sd0;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            s.ms = 16'($urandom_range(0, 100));
        else if (pick < 9)
            s.ms = 16'($urandom_range(0, 2000));
        else
            s.ms = 16'($urandom);
        s.climb = 1'($urandom);
        s.down  = 1'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            s.ovr = -9'sd1;
        else if (pick == 4)
            s.ovr = 9'($urandom_range(256, 510));
        else
            s.ovr = 9'($urandom_range(0, 255));
        return s;
    endfunction

    // Offers one item, waits for it to be taken, then records what it should produce.
    task automatic push_sample(yaw_sample_t s, bit typed, drive_cmd_t want);
        drive_cmd_t pred;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, s.ovr, s.down, s.climb, s.ms, s.gz};
        s_tuser  <= s.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_drive(s);
        drive_expect_q.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= 64'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_reg[idx] = val;
    endtask

    task automatic apply_config(longint vals [8]);
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), vals[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_config(output longint vals [8]);
        vals[REG_RATE_DEADBAND]       = $urandom_range(0, 1500);
        vals[REG_DEVIATION_THRESHOLD] = $urandom_range(0, 3000000);
        vals[REG_GAIN_UPHILL]         = $urandom_range(0, 255);
        vals[REG_GAIN_DOWNHILL]       = $urandom_range(0, 255);
        vals[REG_MAX_CORRECTION]      = $urandom_range(0, 255);
        vals[REG_CLIMB_SPEED]         = $urandom_range(0, 255);
        vals[REG_NORMAL_SPEED]        = $urandom_range(0, 255);
        vals[REG_DOWNHILL_BRAKE]      = $urandom_range(0, 255);
    endtask

    // Result side: compare every accepted item against the oldest expectation.
    always @(posedge clk)
    begin
        drive_cmd_t want;
        drive_cmd_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.drv   = m_tuser;
            got.left  = m_tdata[7:0];
            got.right = m_tdata[15:8];
            got.corr  = m_tdata[24:16];
            got.act   = m_tdata[25];
            got.yaw   = m_tdata[73:26];
            if (drive_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: drv=%0d left=%0d right=%0d yaw=%h",
                             got.drv, got.left, got.right, got.yaw);
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (got.drv !== want.drv || got.left !== want.left
                    || got.right !== want.right || got.corr !== want.corr
                    || got.act !== want.act || got.yaw !== want.yaw)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected drv=%0d left=%0d right=%0d ",
                                  "corr=%0d act=%0d yaw=%h, got drv=%0d left=%0d ",
                                  "right=%0d corr=%0d act=%0d yaw=%h"},
                                 want.drv, want.left, want.right, want.corr, want.act,
                                 want.yaw, got.drv, got.left, got.right, got.corr,
                                 got.act, got.yaw);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        longint     vals [8];
        yaw_sample_t s;
        cfg_reg[REG_RATE_DEADBAND]       = 262;
        cfg_reg[REG_DEVIATION_THRESHOLD] = 163750;
        cfg_reg[REG_GAIN_UPHILL]         = 10;
        cfg_reg[REG_GAIN_DOWNHILL]       = 8;
        cfg_reg[REG_MAX_CORRECTION]      = 45;
        cfg_reg[REG_CLIMB_SPEED]         = 200;
        cfg_reg[REG_NORMAL_SPEED]        = 150;
        cfg_reg[REG_DOWNHILL_BRAKE]      = 80;
        heading = 0;
        heading_active = 1'b0;
        src_gap_pct = 7;
        sink_stall_pct = 47;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            push_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                src_gap_pct = 47;
                sink_stall_pct = 7;
            end
            else if (phase == 4)
            begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            if (phase == 0)
            begin
                vals[REG_RATE_DEADBAND]       = 0;
                vals[REG_DEVIATION_THRESHOLD] = 0;
                vals[REG_GAIN_UPHILL]         = 255;
                vals[REG_GAIN_DOWNHILL]       = 0;
                vals[REG_MAX_CORRECTION]      = 255;
                vals[REG_CLIMB_SPEED]         = 255;
                vals[REG_NORMAL_SPEED]        = 0;
                vals[REG_DOWNHILL_BRAKE]      = 255;
            end
            else if (phase == 2)
            begin
                vals[REG_RATE_DEADBAND]       = 32768;
                vals[REG_DEVIATION_THRESHOLD] = 1000;
                vals[REG_GAIN_UPHILL]         = 0;
                vals[REG_GAIN_DOWNHILL]       = 255;
                vals[REG_MAX_CORRECTION]      = 0;
                vals[REG_CLIMB_SPEED]         = 0;
                vals[REG_NORMAL_SPEED]        = 255;
                vals[REG_DOWNHILL_BRAKE]      = 0;
            end
            else
                random_config(vals);
            apply_config(vals);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_sample(random_sample(), 1'b0, NO_DRIVE);
            wait_drained();
        end

        // Drive the heading far out in both directions with full-scale rates.
        random_config(vals);
        vals[REG_MAX_CORRECTION]      = 255;
        apply_config(vals);
        for (int dir = 0; dir < 2; dir++)
        begin
            s = random_sample();
            s.op = OP_RESET;
            push_sample(s, 1'b0, NO_DRIVE);
            for (int n = 0; n < RAMP_ITEMS; n++)
            begin
                s = random_sample();
                s.op = OP_SAMPLE;
                s.gz = (dir == 0) ? 16'sh7FFF : 16'sh8000;
                s.ms = 16'hFFFF;
                push_sample(s, 1'b0, NO_DRIVE);
            end
        end
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && drive_expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
